>>> src/sptl_pkg.sv
`default_nettype none

package sptl_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
    localparam int SAMPLE_MID  = 1 << (SAMPLE_BITS - 1);
    localparam int THRESHOLD_RESET = 300;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // request codes on the input channel
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_ARM    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // status codes on the result channel
    localparam logic [1:0] STATUS_IDLE    = 2'd0;
    localparam logic [1:0] STATUS_ARMED   = 2'd1;
    localparam logic [1:0] STATUS_LATCHED = 2'd2;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_ARM,
        CMD_CLEAR,
        CMD_NOP
    } cmd_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] sample_value;
        logic [31:0] sample_time_ms;
        logic        sample_source;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [SAMPLE_BITS-1:0] current_value;
        logic [SAMPLE_BITS-1:0] baseline_value;
        logic [SAMPLE_BITS-1:0] peak_value;
        logic [SAMPLE_BITS-1:0] peak_deviation;
        logic [31:0]            trigger_total;
        logic [31:0]            update_time_ms;
        logic [31:0]            trigger_time_ms;
        logic                   last_source;
        logic                   fired_now;
    } out_item_t;

    // classified item as held in the queue
    typedef struct packed {
        cmd_t                   cmd;
        logic [SAMPLE_BITS-1:0] sample;
        logic [31:0]            time_ms;
        logic                   source;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

>>> src/surge_peak_trigger_latch.sv
// Peak-hold detector with an armed threshold trigger.
//
// Input channel (s_valid/s_ready/s_data): one item per transfer, a sample,
// an arm command or a clear command. Result channel (m_valid/m_ready/m_data):
// exactly one snapshot of the detector state per input item, in order.
// Configuration: cfg_wr_en/cfg_wr_data write the trigger threshold; a zero
// value is dropped. Write it only while the block is idle.
//
// Each input item is written into the queue; the execute stage then reads the
// queue head and loads the result register once that register is empty or
// being drained. Throughput: one item per cycle while m_ready does not stall.
//
// A QUEUE_DEPTH entry queue sits between the classifier and the execute stage.
// When m_ready is low the result register holds, the queue fills, and s_ready
// drops once QUEUE_DEPTH items wait; nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and the result register,
// sets the threshold to 300, the detector to idle with all levels mid-scale,
// and zeroes the count and timestamps.
`default_nettype none

module surge_peak_trigger_latch #(
    parameter int QUEUE_DEPTH = sptl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sptl_pkg::SAMPLE_BITS-1:0] cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire sptl_pkg::in_item_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output sptl_pkg::out_item_t               m_data
);

    sptl_pkg::queue_status_t q_status;
    sptl_pkg::entry_t        wr_entry;
    sptl_pkg::entry_t        rd_entry;
    logic                    push;
    logic                    pop;

    sptl_front u_front (
        .in_item  (s_data),
        .q_status (q_status),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .push     (push),
        .entry    (wr_entry)
    );

    sptl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .q_status (q_status)
    );

    sptl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .entry       (rd_entry),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

>>> src/sptl_front.sv
`default_nettype none

module sptl_front (
    input  wire sptl_pkg::in_item_t      in_item,
    input  wire sptl_pkg::queue_status_t q_status,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    output logic                         push,
    output sptl_pkg::entry_t             entry
);

    sptl_pkg::cmd_t cmd;

    always_comb begin
        case (in_item.req_type)
            sptl_pkg::REQ_SAMPLE: cmd = sptl_pkg::CMD_SAMPLE;
            sptl_pkg::REQ_ARM:    cmd = sptl_pkg::CMD_ARM;
            sptl_pkg::REQ_CLEAR:  cmd = sptl_pkg::CMD_CLEAR;
            default:              cmd = sptl_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        entry.cmd     = cmd;
        entry.time_ms = in_item.sample_time_ms;
        entry.source  = in_item.sample_source;
        if (in_item.sample_value > 16'(sptl_pkg::SAMPLE_MAX)) begin
            entry.sample = sptl_pkg::SAMPLE_BITS'(sptl_pkg::SAMPLE_MAX);
        end else begin
            entry.sample = in_item.sample_value[sptl_pkg::SAMPLE_BITS-1:0];
        end
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

endmodule

`default_nettype wire

>>> src/sptl_queue.sv
`default_nettype none

module sptl_queue #(
    parameter int DEPTH = sptl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire sptl_pkg::entry_t        wr_entry,
    input  wire logic                    pop,
    output sptl_pkg::entry_t             rd_entry,
    output sptl_pkg::queue_status_t      q_status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    sptl_pkg::entry_t    slots_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry       = slots_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == CNT_BITS'(DEPTH));

endmodule

`default_nettype wire

>>> src/sptl_back.sv
`default_nettype none

module sptl_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [sptl_pkg::SAMPLE_BITS-1:0] cfg_wr_data,
    input  wire sptl_pkg::queue_status_t     q_status,
    input  wire sptl_pkg::entry_t            entry,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output sptl_pkg::out_item_t              m_data
);

    localparam int SB = sptl_pkg::SAMPLE_BITS;

    // detector mode, encoded as the status code it reports
    typedef enum logic [1:0] {
        MODE_IDLE    = sptl_pkg::STATUS_IDLE,
        MODE_ARMED   = sptl_pkg::STATUS_ARMED,
        MODE_LATCHED = sptl_pkg::STATUS_LATCHED
    } mode_t;

    logic [SB-1:0] threshold_reg;
    mode_t         mode_reg, mode_next;
    logic [SB-1:0] present_reg, present_next;
    logic [SB-1:0] baseline_reg, baseline_next;
    logic [SB-1:0] peak_reg, peak_next;
    logic [SB-1:0] peak_dev_reg, peak_dev_next;
    logic [31:0]   fire_count_reg, fire_count_next;
    logic [31:0]   update_stamp_reg, update_stamp_next;
    logic [31:0]   fire_stamp_reg, fire_stamp_next;
    logic          source_reg, source_next;
    logic          fired;
    logic [SB-1:0] diff;

    logic                m_valid_reg;
    sptl_pkg::out_item_t m_data_reg;

    // result register can take a new snapshot when empty or being drained
    assign pop = q_status.valid && (!m_valid_reg || m_ready);

    assign diff = (entry.sample >= baseline_reg) ? entry.sample - baseline_reg
                                                 : baseline_reg - entry.sample;

    always_comb begin
        mode_next         = mode_reg;
        present_next      = present_reg;
        baseline_next     = baseline_reg;
        peak_next         = peak_reg;
        peak_dev_next     = peak_dev_reg;
        fire_count_next   = fire_count_reg;
        update_stamp_next = update_stamp_reg;
        fire_stamp_next   = fire_stamp_reg;
        source_next       = source_reg;
        fired             = 1'b0;
        case (entry.cmd)
            sptl_pkg::CMD_SAMPLE: begin
                present_next      = entry.sample;
                source_next       = entry.source;
                update_stamp_next = entry.time_ms;
                if (mode_reg != MODE_IDLE) begin
                    if (diff > peak_dev_reg) begin
                        peak_dev_next = diff;
                        peak_next     = entry.sample;
                    end
                    if (mode_reg == MODE_ARMED && diff >= threshold_reg) begin
                        mode_next       = MODE_LATCHED;
                        fire_count_next = fire_count_reg + 32'd1;
                        fire_stamp_next = entry.time_ms;
                        fired           = 1'b1;
                    end
                end
            end
            sptl_pkg::CMD_ARM: begin
                mode_next     = MODE_ARMED;
                baseline_next = present_reg;
                peak_next     = present_reg;
                peak_dev_next = '0;
            end
            sptl_pkg::CMD_CLEAR: begin
                mode_next       = MODE_IDLE;
                baseline_next   = present_reg;
                peak_next       = present_reg;
                peak_dev_next   = '0;
                fire_stamp_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= SB'(sptl_pkg::THRESHOLD_RESET);
            mode_reg         <= MODE_IDLE;
            present_reg      <= SB'(sptl_pkg::SAMPLE_MID);
            baseline_reg     <= SB'(sptl_pkg::SAMPLE_MID);
            peak_reg         <= SB'(sptl_pkg::SAMPLE_MID);
            peak_dev_reg     <= '0;
            fire_count_reg   <= '0;
            update_stamp_reg <= '0;
            fire_stamp_reg   <= '0;
            source_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
        end else begin
            // a zero threshold write is dropped
            if (cfg_wr_en && cfg_wr_data != '0) begin
                threshold_reg <= cfg_wr_data;
            end
            if (pop) begin
                mode_reg         <= mode_next;
                present_reg      <= present_next;
                baseline_reg     <= baseline_next;
                peak_reg         <= peak_next;
                peak_dev_reg     <= peak_dev_next;
                fire_count_reg   <= fire_count_next;
                update_stamp_reg <= update_stamp_next;
                fire_stamp_reg   <= fire_stamp_next;
                source_reg       <= source_next;
                m_valid_reg      <= 1'b1;

                m_data_reg.status          <= mode_next;
                m_data_reg.current_value   <= present_next;
                m_data_reg.baseline_value  <= baseline_next;
                m_data_reg.peak_value      <= peak_next;
                m_data_reg.peak_deviation  <= peak_dev_next;
                m_data_reg.trigger_total   <= fire_count_next;
                m_data_reg.update_time_ms  <= update_stamp_next;
                m_data_reg.trigger_time_ms <= fire_stamp_next;
                m_data_reg.last_source     <= source_next;
                m_data_reg.fired_now       <= fired;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> src/sptl_checker.sv
`default_nettype none

module sptl_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire sptl_pkg::out_item_t m_data
);

    // a firing snapshot always reports the latched state
    a_fire_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fired_now) |-> (m_data.status == sptl_pkg::STATUS_LATCHED))
        else $error("fired_now without latched status");

    // zero deviation means the peak is still the baseline
    a_peak_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.peak_deviation == '0) |-> (m_data.peak_value == m_data.baseline_value))
        else $error("peak moved with zero deviation");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind surge_peak_trigger_latch sptl_checker u_sptl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
